// File: rtl/vbbc_pkg.sv
// Shared constants, codes and types for the voxel bounding box clusterer.
// Depends on nothing; used by vbbc_cell and the top level.
`timescale 1ns / 1ps
package vbbc_pkg;

	localparam int MAX_BOXES_DEF  = 64;
	localparam int COORD_BITS_DEF = 20;

	localparam int SIZE_W  = 16;
	localparam int COLOR_W = 8;
	localparam int DIST_W  = 16;
	localparam int LIM_W   = 2 * DIST_W;
	localparam int ACT_W   = 2;
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd0;
	localparam logic [ACT_W-1:0] ACT_NEW     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MERGED  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_DROPPED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CLASS_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_BLUE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_DIST  = 2'd3;

	localparam logic [COLOR_W-1:0] RED_RST   = 8'd64;
	localparam logic [COLOR_W-1:0] GREEN_RST = 8'd0;
	localparam logic [COLOR_W-1:0] BLUE_RST  = 8'd128;
	localparam logic [DIST_W-1:0]  DIST_RST  = 16'd128;

	// Priority chain running from cell 0 upwards.
	typedef struct packed {
		logic found;
	} chain_t;

endpackage

// File: rtl/vbbc_cell.sv
// One box cell: stores one box, tests the current voxel against it and takes
// part in the lowest-index priority chain. Depends on vbbc_pkg.
`timescale 1ns / 1ps
module vbbc_cell #(
	parameter int COORD_BITS = vbbc_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmp_en,
	input  logic signed [COORD_BITS-1:0] vox_x,
	input  logic signed [COORD_BITS-1:0] vox_y,
	input  logic [vbbc_pkg::LIM_W-1:0]  lim,
	input  logic                        live,
	input  logic                        wr_en,
	input  logic [6*COORD_BITS-1:0]     wr_box,
	input  vbbc_pkg::chain_t            chain_in,
	output vbbc_pkg::chain_t            chain_out,
	input  logic [6*COORD_BITS-1:0]     gath_in,
	output logic [6*COORD_BITS-1:0]     gath_out,
	output logic                        hit
);
	import vbbc_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int GW = (C + 1 > DIST_W + 1) ? C + 1 : DIST_W + 1;

	// Box word: min_x, max_x, min_y, max_y, centre_x, centre_y from the lowest bit.
	logic [6*C-1:0] box_q;
	logic           match_q;

	logic signed [C-1:0] min_x, max_x, min_y, max_y;
	logic signed [C:0]   bx, ax, by, ay;
	logic [GW-1:0]       gx, gy;
	logic                far_x, far_y;
	logic [DIST_W-1:0]   dx, dy;
	logic [LIM_W-1:0]    sqx, sqy;
	logic [LIM_W:0]      dsq;
	logic                match_d;

	assign min_x = box_q[C-1:0];
	assign max_x = box_q[2*C-1:C];
	assign min_y = box_q[3*C-1:2*C];
	assign max_y = box_q[4*C-1:3*C];

	always_comb begin
		bx = (C+1)'(min_x) - (C+1)'(vox_x);
		ax = (C+1)'(vox_x) - (C+1)'(max_x);
		by = (C+1)'(min_y) - (C+1)'(vox_y);
		ay = (C+1)'(vox_y) - (C+1)'(max_y);
		gx = '0;
		gy = '0;
		if (bx > 0) begin
			gx = GW'($unsigned(bx));
		end else if (ax > 0) begin
			gx = GW'($unsigned(ax));
		end
		if (by > 0) begin
			gy = GW'($unsigned(by));
		end else if (ay > 0) begin
			gy = GW'($unsigned(ay));
		end
		// A gap of a full 2^16 or more always exceeds the largest limit.
		far_x = gx > GW'({DIST_W{1'b1}});
		far_y = gy > GW'({DIST_W{1'b1}});
		dx = gx[DIST_W-1:0];
		dy = gy[DIST_W-1:0];
		sqx = {{(LIM_W-DIST_W){1'b0}}, dx} * {{(LIM_W-DIST_W){1'b0}}, dx};
		sqy = {{(LIM_W-DIST_W){1'b0}}, dy} * {{(LIM_W-DIST_W){1'b0}}, dy};
		dsq = {1'b0, sqx} + {1'b0, sqy};
		match_d = !far_x && !far_y && (dsq <= {1'b0, lim});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmp_en) begin
			match_q <= match_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			box_q <= wr_box;
		end
	end

	assign hit             = match_q && live && !chain_in.found;
	assign chain_out.found = chain_in.found || (match_q && live);
	assign gath_out        = gath_in | (hit ? box_q : '0);

endmodule

// File: rtl/voxel_bounding_box_clusterer.sv
// Top level of the voxel bounding box clusterer: control, the row of box
// cells and the result register. Depends on vbbc_pkg and vbbc_cell.
`timescale 1ns / 1ps
// Usage
// Voxels arrive as beats on the s_ channel and each one gives exactly one
// result beat on the m_ channel, in order. A voxel whose colour differs from
// the class colour is reported as ignored. Otherwise it is merged into the
// lowest-index stored box within merge_distance, or starts a new box, or is
// reported as dropped when all MAX_BOXES boxes are in use.
// An accepted voxel is captured at the accepting edge and then passes in turn
// through compare in every cell at once, priority pick along the cell chain,
// and write-back with the result loaded into the output register.
// A new voxel is taken only once the block is back in idle after the previous
// write-back: the steps of one voxel do not overlap with the next, since each
// voxel must be compared against the table as the previous one left it.
// When the receiver stalls, the finished result waits in the output register;
// the next voxel is still accepted and held at write-back until the result
// register is free. Configuration beats on the cfg_ channel are always taken
// and must only be sent while no voxel is in flight.
// Reset empties the box table (the count returns to zero) and loads the
// register defaults; no clearing pass is needed, since only boxes below the
// count are ever read.
module voxel_bounding_box_clusterer #(
	parameter int MAX_BOXES  = vbbc_pkg::MAX_BOXES_DEF,
	parameter int COORD_BITS = vbbc_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// voxel_x, voxel_y, voxel_size, voxel_red, voxel_green, voxel_blue, zero fill
	input  logic [((2*COORD_BITS+vbbc_pkg::SIZE_W+3*vbbc_pkg::COLOR_W+7)/8)*8-1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// action, box_index, box_count, left_edge, right_edge, bottom_edge,
	// top_edge, mid_x, mid_y, zero fill
	output logic [((vbbc_pkg::ACT_W+vbbc_pkg::IDX_OUT_W+vbbc_pkg::CNT_OUT_W
		+6*COORD_BITS+7)/8)*8-1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [vbbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vbbc_pkg::DIST_W-1:0] cfg_data
);
	import vbbc_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int N     = MAX_BOXES;
	localparam int IDX_W = $clog2(N);
	localparam int CNT_W = $clog2(N + 1);
	localparam int OUT_USED = ACT_W + IDX_OUT_W + CNT_OUT_W + 6 * C;
	localparam int OUT_W = ((OUT_USED + 7) / 8) * 8;
	// Width of a coordinate plus or minus a padding, before saturation.
	localparam int EW    = ((C > SIZE_W) ? C : SIZE_W) + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	logic [1:0] state_q;

	logic [COLOR_W-1:0] red_q, green_q, blue_q;
	logic [DIST_W-1:0]  dist_q;
	logic [LIM_W-1:0]   lim_q;

	logic signed [C-1:0] x_q, y_q;
	logic [SIZE_W-1:0]   size_q;
	logic                colour_ok_q;

	logic [CNT_W-1:0] count_q;
	logic             found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [6*C-1:0]   old_q;

	// Result register
	logic                out_v_q;
	logic [ACT_W-1:0]    act_q;
	logic [IDX_OUT_W-1:0] idx_out_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;
	logic [6*C-1:0]      res_box_q;

	chain_t           chain [N+1];
	logic [6*C-1:0]   gath [N+1];
	logic [N-1:0]     hits;
	logic [N-1:0]     wr_en;
	logic [6*C-1:0]   wr_box;

	logic             accept, go;
	logic [IDX_W-1:0] hit_idx_d;
	logic [ACT_W-1:0] act_d;
	logic [IDX_W-1:0] tgt_idx;
	logic [SIZE_W-1:0] pad;
	logic signed [C-1:0] lo_x, hi_x, lo_y, hi_y, cx, cy;
	logic signed [C-1:0] o_min_x, o_max_x, o_min_y, o_max_y;
	logic [CNT_W-1:0] count_d;
	logic [31:0]      idx_wide, cnt_wide;

	function automatic logic signed [C-1:0] sat(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] cmax, cmin;
		cmax = EW'({1'b0, {(C-1){1'b1}}});
		cmin = -cmax - EW'(1);
		if (v > cmax) begin
			sat = cmax[C-1:0];
		end else if (v < cmin) begin
			sat = cmin[C-1:0];
		end else begin
			sat = v[C-1:0];
		end
	endfunction

	function automatic logic signed [C-1:0] fmid(input logic signed [C-1:0] a,
		input logic signed [C-1:0] b);
		logic signed [C:0] s;
		s = (C+1)'(a) + (C+1)'(b);
		fmid = s[C:1];
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign go        = (state_q == ST_WR) && (!out_v_q || m_tready);

	// Configuration registers; the squared limit is kept ready for the cells.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= RED_RST;
			green_q <= GREEN_RST;
			blue_q  <= BLUE_RST;
			dist_q  <= DIST_RST;
			lim_q   <= LIM_W'(DIST_RST) * LIM_W'(DIST_RST);
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CLASS_RED:   red_q   <= cfg_data[COLOR_W-1:0];
					REG_CLASS_GREEN: green_q <= cfg_data[COLOR_W-1:0];
					REG_CLASS_BLUE:  blue_q  <= cfg_data[COLOR_W-1:0];
					REG_MERGE_DIST:  dist_q  <= cfg_data;
					default:         dist_q  <= dist_q;
				endcase
			end
			lim_q <= LIM_W'(dist_q) * LIM_W'(dist_q);
		end
	end

	// Voxel capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= s_tdata[C-1:0];
			y_q    <= s_tdata[2*C-1:C];
			size_q <= s_tdata[2*C+SIZE_W-1:2*C];
			colour_ok_q <=
				(s_tdata[2*C+SIZE_W+COLOR_W-1:2*C+SIZE_W] == red_q) &&
				(s_tdata[2*C+SIZE_W+2*COLOR_W-1:2*C+SIZE_W+COLOR_W] == green_q) &&
				(s_tdata[2*C+SIZE_W+3*COLOR_W-1:2*C+SIZE_W+2*COLOR_W] == blue_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_SEL;
				ST_SEL:  state_q <= ST_WR;
				ST_WR:   if (go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The row of cells. The chain carries "a lower box already matched" and
	// an OR-gathered copy of the first matching box.
	assign chain[0] = '{found: 1'b0};
	assign gath[0]  = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		vbbc_cell #(.COORD_BITS(C)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmp_en    (state_q == ST_CMP),
			.vox_x     (x_q),
			.vox_y     (y_q),
			.lim       (lim_q),
			.live      (CNT_W'(i) < count_q),
			.wr_en     (wr_en[i]),
			.wr_box    (wr_box),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.gath_in   (gath[i]),
			.gath_out  (gath[i+1]),
			.hit       (hits[i])
		);
	end

	always_comb begin
		hit_idx_d = '0;
		for (int i = 0; i < N; i++) begin
			if (hits[i]) begin
				hit_idx_d = hit_idx_d | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEL) begin
			found_q   <= chain[N].found;
			hit_idx_q <= hit_idx_d;
			old_q     <= gath[N];
		end
	end

	// Write-back: decide the action and build the new box.
	assign o_min_x = old_q[C-1:0];
	assign o_max_x = old_q[2*C-1:C];
	assign o_min_y = old_q[3*C-1:2*C];
	assign o_max_y = old_q[4*C-1:3*C];

	always_comb begin
		act_d   = ACT_IGNORED;
		tgt_idx = '0;
		count_d = count_q;
		if (colour_ok_q) begin
			if (found_q) begin
				act_d   = ACT_MERGED;
				tgt_idx = hit_idx_q;
			end else if (count_q >= CNT_W'(N)) begin
				act_d = ACT_DROPPED;
			end else begin
				act_d   = ACT_NEW;
				tgt_idx = count_q[IDX_W-1:0];
				count_d = count_q + CNT_W'(1);
			end
		end
		// The first box after reset gets the full voxel size as padding.
		pad = (act_d == ACT_NEW && count_q == '0) ? size_q : (size_q >> 1);
		lo_x = sat(EW'(x_q) - EW'(pad));
		hi_x = sat(EW'(x_q) + EW'(pad));
		lo_y = sat(EW'(y_q) - EW'(pad));
		hi_y = sat(EW'(y_q) + EW'(pad));
		cx = x_q;
		cy = y_q;
		if (act_d == ACT_MERGED) begin
			if (o_min_x < lo_x) lo_x = o_min_x;
			if (o_max_x > hi_x) hi_x = o_max_x;
			if (o_min_y < lo_y) lo_y = o_min_y;
			if (o_max_y > hi_y) hi_y = o_max_y;
			cx = fmid(lo_x, hi_x);
			cy = fmid(lo_y, hi_y);
		end
		wr_box = {cy, cx, hi_y, lo_y, hi_x, lo_x};
		for (int i = 0; i < N; i++) begin
			wr_en[i] = go && (act_d == ACT_NEW || act_d == ACT_MERGED) &&
				(tgt_idx == IDX_W'(i));
		end
		idx_wide = 32'(tgt_idx);
		cnt_wide = 32'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (go) begin
				count_q <= count_d;
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			act_q     <= act_d;
			cnt_out_q <= cnt_wide[CNT_OUT_W-1:0];
			if (act_d == ACT_NEW || act_d == ACT_MERGED) begin
				idx_out_q <= idx_wide[IDX_OUT_W-1:0];
				res_box_q <= wr_box;
			end else begin
				idx_out_q <= '0;
				res_box_q <= '0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(OUT_W-OUT_USED){1'b0}}, res_box_q, cnt_out_q, idx_out_q, act_q};

	// The box count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(N))
		else $error("box count beyond table size");

	// The count only ever grows by one, and only at a write-back.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(go) && count_q == $past(count_q) + CNT_W'(1)))
		else $error("box count changed unexpectedly");

	// At most one cell is written at a time.
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_en))
		else $error("several cells written at once");

	// A finished voxel always produces a pending result.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_v_q && state_q == ST_IDLE)
		else $error("write-back without result");

endmodule

// File: tb/sv/tb_voxel_bounding_box_clusterer.sv
// Self-checking testbench for the voxel bounding box clusterer top level.
// Depends on vbbc_pkg and voxel_bounding_box_clusterer; it keeps its own copy
// of the box table and predicts the result beat of every voxel it sends.
`timescale 1ns / 1ps
module tb_voxel_bounding_box_clusterer;
	import vbbc_pkg::*;

	localparam int CB      = COORD_BITS_DEF;
	localparam int NBOX    = MAX_BOXES_DEF;
	localparam longint CMAX = (longint'(1) <<< (CB - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam int S_W     = ((2*CB + SIZE_W + 3*COLOR_W + 7) / 8) * 8;
	localparam int M_W     = ((ACT_W + IDX_OUT_W + CNT_OUT_W + 6*CB + 7) / 8) * 8;
	// A whole idle window with no beat of any kind ends the run.
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic [SIZE_W-1:0] size;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] x;
	} voxel_t;

	typedef struct packed {
		logic [CB-1:0] mid_y;
		logic [CB-1:0] mid_x;
		logic [CB-1:0] top;
		logic [CB-1:0] bottom;
		logic [CB-1:0] right;
		logic [CB-1:0] left;
		logic [CNT_OUT_W-1:0] count;
		logic [IDX_OUT_W-1:0] index;
		logic [ACT_W-1:0] action;
	} box_report_t;

	logic clk;
	logic arst_n;
	logic [S_W-1:0] s_tdata;
	logic s_tvalid;
	logic s_tready;
	logic [M_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIST_W-1:0] cfg_data;

	voxel_bounding_box_clusterer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Our own image of the box table and of the configuration registers.
	longint tbl_min_x[NBOX];
	longint tbl_max_x[NBOX];
	longint tbl_min_y[NBOX];
	longint tbl_max_y[NBOX];
	longint tbl_mid_x[NBOX];
	longint tbl_mid_y[NBOX];
	int tbl_used;
	logic [COLOR_W-1:0] want_red, want_green, want_blue;
	logic [DIST_W-1:0] join_dist;

	box_report_t pending_reports[$];
	int mismatches;
	int idle_cycles;
	bit tx_steady;      // sender offers back to back when set
	bit rx_steady;      // receiver starts no new stalls when set
	int rx_hold_req;    // asks the receiver for a long hold-off
	int rx_stall_left;

	function automatic longint clamp_coord(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic longint axis_gap(longint lo, longint hi, longint p);
		if (lo - p > 0) return lo - p;
		if (p - hi > 0) return p - hi;
		return 0;
	endfunction

	// Works out the result beat of one voxel and updates the table image.
	function automatic box_report_t cluster_voxel(voxel_t v);
		box_report_t r;
		longint x, y, sz, half, pad, dx, dy;
		longint unsigned lim;
		int hit;
		r = '0;
		x = longint'(v.x);
		y = longint'(v.y);
		sz = longint'(v.size);
		half = sz >>> 1;
		hit = -1;
		if (v.red == want_red && v.green == want_green && v.blue == want_blue) begin
			lim = longint'(join_dist) * longint'(join_dist);
			for (int i = 0; i < tbl_used; i++) begin
				dx = axis_gap(tbl_min_x[i], tbl_max_x[i], x);
				dy = axis_gap(tbl_min_y[i], tbl_max_y[i], y);
				if (hit < 0 && longint'(dx * dx + dy * dy) <= lim)
					hit = i;
			end
			if (hit >= 0) begin
				if (clamp_coord(x - half) < tbl_min_x[hit]) tbl_min_x[hit] = clamp_coord(x - half);
				if (clamp_coord(x + half) > tbl_max_x[hit]) tbl_max_x[hit] = clamp_coord(x + half);
				if (clamp_coord(y - half) < tbl_min_y[hit]) tbl_min_y[hit] = clamp_coord(y - half);
				if (clamp_coord(y + half) > tbl_max_y[hit]) tbl_max_y[hit] = clamp_coord(y + half);
				// Floor of the mean: an arithmetic shift rounds towards minus infinity.
				tbl_mid_x[hit] = (tbl_min_x[hit] + tbl_max_x[hit]) >>> 1;
				tbl_mid_y[hit] = (tbl_min_y[hit] + tbl_max_y[hit]) >>> 1;
				r.action = ACT_MERGED;
			end else if (tbl_used >= NBOX) begin
				r.action = ACT_DROPPED;
			end else begin
				// Only the very first box after reset gets the full voxel size.
				pad = (tbl_used == 0) ? sz : half;
				hit = tbl_used;
				tbl_min_x[hit] = clamp_coord(x - pad);
				tbl_max_x[hit] = clamp_coord(x + pad);
				tbl_min_y[hit] = clamp_coord(y - pad);
				tbl_max_y[hit] = clamp_coord(y + pad);
				tbl_mid_x[hit] = x;
				tbl_mid_y[hit] = y;
				tbl_used++;
				r.action = ACT_NEW;
			end
		end
		r.count = tbl_used[CNT_OUT_W-1:0];
		if (r.action == ACT_NEW || r.action == ACT_MERGED) begin
			r.index = hit[IDX_OUT_W-1:0];
			r.left = tbl_min_x[hit][CB-1:0];
			r.right = tbl_max_x[hit][CB-1:0];
			r.bottom = tbl_min_y[hit][CB-1:0];
			r.top = tbl_max_y[hit][CB-1:0];
			r.mid_x = tbl_mid_x[hit][CB-1:0];
			r.mid_y = tbl_mid_y[hit][CB-1:0];
		end
		return r;
	endfunction

	function automatic voxel_t make_voxel(longint x, longint y, int sz, int in_class);
		voxel_t v;
		v.x = x[CB-1:0];
		v.y = y[CB-1:0];
		v.size = sz[SIZE_W-1:0];
		if (in_class != 0) begin
			v.red = want_red;
			v.green = want_green;
			v.blue = want_blue;
		end else begin
			v.red = COLOR_W'($urandom);
			v.green = COLOR_W'($urandom);
			v.blue = COLOR_W'($urandom);
		end
		return v;
	endfunction

	// Random voxel near a centre; now and then one anywhere at all, with any size
	// and a colour in or off the class at random, so that every input bit is exercised.
	function automatic voxel_t random_voxel(longint cx, longint cy, int spread);
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return make_voxel($urandom, $urandom, $urandom, $urandom_range(1));
		return make_voxel(cx + $signed($urandom_range(2 * spread)) - spread,
			cy + $signed($urandom_range(2 * spread)) - spread,
			$urandom_range(511), roll < 85);
	endfunction

	// Sends one voxel beat. Returns at the edge that accepted it, valid still high.
	task automatic send_voxel(input voxel_t v);
		int gap_len;
		int roll;
		gap_len = 0;
		roll = $urandom_range(99);
		if (!tx_steady) begin
			if (roll >= 95)
				gap_len = $urandom_range(30, 10);
			else if (roll >= 60)
				gap_len = $urandom_range(3, 1);
		end
		if (gap_len > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_len) @(posedge clk);
		end
		s_tdata <= S_W'(v);
		s_tvalid <= 1'b1;
		pending_reports.insert(pending_reports.size(), cluster_voxel(v));
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	// Stops offering and waits until every result beat has come back, then lets
	// the pipeline settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
		drain_results();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CLASS_RED: want_red = val[COLOR_W-1:0];
			REG_CLASS_GREEN: want_green = val[COLOR_W-1:0];
			REG_CLASS_BLUE: want_blue = val[COLOR_W-1:0];
			REG_MERGE_DIST: join_dist = val;
			default: ;
		endcase
	endtask

	task automatic set_class(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
		input logic [COLOR_W-1:0] b);
		write_reg(REG_CLASS_RED, DIST_W'(r));
		write_reg(REG_CLASS_GREEN, DIST_W'(g));
		write_reg(REG_CLASS_BLUE, DIST_W'(b));
	endtask

	// Default colour and distance, the full padding of the first box, a merge,
	// an off-class voxel, voxels at all four corners, saturation and a size of zero.
	task automatic test_directed_defaults();
		send_voxel(make_voxel(0, 0, 256, 1));
		send_voxel(make_voxel(256 + 100, 50, 3, 1));
		send_voxel(make_voxel(0, 0, 256, 0));
		send_voxel(make_voxel(10, 10, 256, 1));
		send_voxel(make_voxel(CMAX, CMIN, 65535, 1));
		send_voxel(make_voxel(CMIN, CMAX, 65535, 1));
		send_voxel(make_voxel(CMAX, CMAX, 0, 1));
		send_voxel(make_voxel(CMIN, CMIN, 1, 1));
		send_voxel(make_voxel(CMAX - 5, CMAX - 5, 65535, 1));
		send_voxel(make_voxel(3001, -3001, 7, 1));
		send_voxel(make_voxel(3001, -3001, 0, 1));
		send_voxel(make_voxel(3002, -2999, 5, 1));
	endtask

	// With a zero distance only a voxel on or inside a box joins it; then the largest distance is tried.
	task automatic test_zero_distance();
		write_reg(REG_MERGE_DIST, 16'd0);
		send_voxel(make_voxel(40000, 40000, 200, 1));
		send_voxel(make_voxel(40100, 40000, 2, 1));
		send_voxel(make_voxel(40101, 40000, 2, 1));
		send_voxel(make_voxel(40000, 39899, 2, 1));
		send_voxel(make_voxel(40099, 39900, 0, 1));
		write_reg(REG_MERGE_DIST, 16'd65535);
		send_voxel(make_voxel(-100000, -100000, 100, 1));
		send_voxel(make_voxel(-100000 + 65535 + 8, -100000, 100, 1));
		send_voxel(make_voxel(CMIN + 20, CMIN + 20, 3, 1));
	endtask

	// Class colour at its extremes; voxels one bit off in the green or the blue component.
	task automatic test_class_colour();
		set_class(8'd255, 8'd255, 8'd255);
		send_voxel(make_voxel(1000, 1000, 64, 1));
		send_voxel('{blue: 8'hFF, green: 8'hFE, red: 8'hFF, size: 16'd64, y: 20'sd1000,
			x: 20'sd1000});
		set_class(8'd0, 8'd0, 8'd0);
		send_voxel(make_voxel(1000, 1000, 64, 1));
		send_voxel('{blue: 8'h01, green: 8'h00, red: 8'h00, size: 16'd64, y: 20'sd1000,
			x: 20'sd1000});
		set_class(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
			COLOR_W'($urandom_range(255)));
	endtask

	// Clusters at random centres, with a new distance for each phase.
	task automatic test_random_clusters(input int n_items);
		longint cx, cy;
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_MERGE_DIST, DIST_W'($urandom_range(1024)));
			cx = $signed($urandom_range(2000000)) - 1000000;
			cy = $signed($urandom_range(2000000)) - 1000000;
			tx_steady = (ph == 2);
			rx_steady = (ph == 2);
			for (int i = 0; i < n_items / 4; i++)
				send_voxel(random_voxel(cx >>> 1, cy >>> 1, 2000));
		end
		tx_steady = 0;
		rx_steady = 0;
	endtask

	// The receiver holds off for a long stretch while voxels keep coming, so
	// the block fills up and has to stall its input.
	task automatic test_receiver_hold(input int n_items);
		tx_steady = 1;
		rx_hold_req = 300;
		for (int i = 0; i < n_items; i++)
			send_voxel(random_voxel(-20000, 20000, 3000));
		tx_steady = 0;
	endtask

	// Bursts separated by a full drain of the results.
	task automatic test_sender_pause(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			send_voxel(random_voxel(60000, -60000, 4000));
			if (i % 10 == 9)
				drain_results();
		end
	endtask

	// Scattered voxels with a zero distance fill the table; past that point
	// voxels far from every box are dropped and close ones still merge.
	task automatic test_full_table(input int n_items);
		voxel_t v;
		write_reg(REG_MERGE_DIST, 16'd0);
		while (tbl_used < NBOX) begin
			v = make_voxel($urandom, $urandom, $urandom_range(255), 1);
			send_voxel(v);
		end
		write_reg(REG_MERGE_DIST, DIST_W'($urandom_range(65535)));
		for (int i = 0; i < n_items; i++) begin
			if (i % 3 == 0)
				v = make_voxel($urandom, $urandom, $urandom, $urandom_range(99) < 85);
			else
				v = random_voxel(tbl_mid_x[$urandom_range(NBOX - 1)],
					tbl_mid_y[$urandom_range(NBOX - 1)], 600);
			send_voxel(v);
		end
		write_reg(REG_MERGE_DIST, 16'd65535);
		for (int i = 0; i < 30; i++)
			send_voxel(make_voxel($urandom, $urandom, $urandom, 1));
	endtask

	// Receiver: mostly ready, short stalls now and then, a few long ones, and
	// a long hold-off on request.
	always @(posedge clk) begin
		if (rx_hold_req > 0) begin
			rx_stall_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if (rx_steady || $urandom_range(99) < 70) begin
			m_tready <= 1'b1;
		end else begin
			rx_stall_left = ($urandom_range(99) < 90) ? $urandom_range(3, 1)
				: $urandom_range(40, 10);
			m_tready <= 1'b0;
		end
	end

	// All handshakes are sampled at the falling edge ahead of the rising edge that takes
	// them: every input changes only at rising edges, so the value is settled.
	always @(negedge clk) begin
		box_report_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(box_report_t)-1:0];
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got);
			end else begin
				want = pending_reports.pop_front();
				if (got.action !== want.action || got.index !== want.index
					|| got.count !== want.count || got.left !== want.left
					|| got.right !== want.right || got.bottom !== want.bottom
					|| got.top !== want.top || got.mid_x !== want.mid_x
					|| got.mid_y !== want.mid_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("voxel_bounding_box_clusterer test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CLASS_RED;
		cfg_data <= '0;
		mismatches = 0;
		idle_cycles = 0;
		tx_steady = 0;
		rx_steady = 0;
		rx_hold_req = 0;
		rx_stall_left = 0;
		tbl_used = 0;
		want_red = RED_RST;
		want_green = GREEN_RST;
		want_blue = BLUE_RST;
		join_dist = DIST_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_zero_distance();
		test_class_colour();
		test_random_clusters(380);
		test_receiver_hold(40);
		test_sender_pause(40);
		test_full_table(220);

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("voxel_bounding_box_clusterer test passed");
		else
			$display("voxel_bounding_box_clusterer test failed");
		$finish;
	end

endmodule
